>>> src/aqpd_pkg.sv
// Shared constants, register codes and the command and status types of the QRS detector.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package aqpd_pkg;

	localparam int BUF_DEPTH = 8;
	localparam int IDX_W     = $clog2(BUF_DEPTH);
	localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
	localparam int MED_RANK  = (BUF_DEPTH - 1) / 2;

	localparam int SAMPLE_W  = 16;
	localparam int COUNT_W   = 16;
	localparam int MED_W     = COUNT_W;
	localparam int THR_W     = SAMPLE_W + 1;

	localparam int GAIN_W    = 15;
	localparam int GAIN_FRAC = 15;
	localparam int PROD_W    = SAMPLE_W + GAIN_W + 2;
	localparam int BYTE_W    = 8;
	localparam int SEC_W     = 10;
	localparam int DELAY_W   = 12;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [GAIN_W-1:0] GAIN_RST  = 15'd15565;
	localparam logic [BYTE_W-1:0] HOLD_RST  = 8'd40;
	localparam logic [SEC_W-1:0]  SEC_RST   = 10'd200;
	localparam logic [BYTE_W-1:0] PTO_RST   = 8'd19;
	localparam logic [BYTE_W-1:0] WIN_RST   = 8'd16;
	localparam logic [BYTE_W-1:0] FDLY_RST  = 8'd57;
	localparam logic [SEC_W-1:0]  SBMIN_RST = 10'd72;

	localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEC   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PTO   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FDLY  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SBMIN = 3'd6;

	typedef logic [1:0] med_src_t;
	localparam med_src_t SRC_QRS   = 2'd0;
	localparam med_src_t SRC_NOISE = 2'd1;
	localparam med_src_t SRC_RR    = 2'd2;

	typedef struct packed {
		logic             accept;
		logic             clear;
		logic             peak;
		logic             learn;
		logic             detect;
		logic             sb;
		logic             relearn;
		logic             med_step;
		logic             med_apply;
		logic             thr_mul;
		logic             thr_add;
		logic             out_load;
		med_src_t         med_sel;
		logic [IDX_W-1:0] med_idx;
	} aqpd_cmd_t;

	typedef struct packed {
		logic learning;
		logic learn_done;
		logic det_qrs;
		logic det_noise;
		logic sb_hit;
		logic rel_done;
		logic out_busy;
	} aqpd_stat_t;

endpackage
`default_nettype wire

>>> src/aqpd_if.sv
// Handshake channels of the QRS detector: sample input, result output and register writes.
// Depends on aqpd_pkg for the field widths.
`default_nettype none
interface aqpd_sample_if import aqpd_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] filtered_sample;
	logic                restart;
	modport source(output valid, filtered_sample, restart, input ready);
	modport sink(input valid, filtered_sample, restart, output ready);
endinterface

interface aqpd_result_if import aqpd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DELAY_W-1:0] qrs_delay;
	modport source(output valid, qrs_delay, input ready);
	modport sink(input valid, qrs_delay, output ready);
endinterface

interface aqpd_cfg_if import aqpd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/adaptive_qrs_peak_detector.sv
// Top level of the adaptive QRS peak detector: sequencer, datapath and channel hookup.
// Depends on aqpd_pkg, aqpd_if, aqpd_ctrl and aqpd_dp.
//
//   channel    dir  beat carries
//   sample_ch  in   filtered_sample[15:0], restart
//   result_ch  out  qrs_delay[11:0] (0 = no beat)
//   cfg        in   index[2:0], data[14:0]; always ready
//
// A sample passes accept, clear and peak, then learn while learning, or detect,
// search-back and re-learn once learned, and ends in the result load; every threshold
// update adds a median scan, median apply, multiply and add, and every beat an RR median.
// The median scan ranks one buffer entry per cycle.
// Reset and restart need no clearing pass; buffers reset in place.
// A waiting result does not block the next sample, only the result after it.
`default_nettype none
module adaptive_qrs_peak_detector import aqpd_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	aqpd_sample_if.sink   sample_ch,
	aqpd_result_if.source result_ch,
	aqpd_cfg_if.sink      cfg
);

	aqpd_cmd_t  cmd;
	aqpd_stat_t st;

	assign cfg.ready = 1'b1;

	aqpd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_ch.valid),
		.in_ready (sample_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	aqpd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.in_sample  (sample_ch.filtered_sample),
		.in_restart (sample_ch.restart),
		.cfg_we     (cfg.valid),
		.cfg_idx    (cfg.index),
		.cfg_data   (cfg.data),
		.out_valid  (result_ch.valid),
		.out_ready  (result_ch.ready),
		.out_delay  (result_ch.qrs_delay)
	);

	// One sample at a time: no second beat is taken right after one.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_ch.valid && sample_ch.ready) |=> !sample_ch.ready)
		else $error("sample taken while previous one in work");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> result_ch.valid)
		else $error("loaded result not presented");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.med_step, cmd.thr_mul, cmd.thr_add, cmd.out_load}))
		else $error("conflicting datapath commands");

	a_thr_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.thr_mul |=> cmd.thr_add)
		else $error("threshold add did not follow multiply");

endmodule
`default_nettype wire

>>> src/aqpd_ctrl.sv
// Sequencer of the QRS detector: walks each sample through the decision steps and
// runs the median and threshold subroutines. Depends on aqpd_pkg.
`default_nettype none
module aqpd_ctrl import aqpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  aqpd_stat_t st,
	output aqpd_cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CLEAR = 4'd1;
	localparam logic [3:0] ST_PEAK  = 4'd2;
	localparam logic [3:0] ST_LEARN = 4'd3;
	localparam logic [3:0] ST_DET   = 4'd4;
	localparam logic [3:0] ST_SB    = 4'd5;
	localparam logic [3:0] ST_REL   = 4'd6;
	localparam logic [3:0] ST_MED   = 4'd7;
	localparam logic [3:0] ST_MAPP  = 4'd8;
	localparam logic [3:0] ST_THR1  = 4'd9;
	localparam logic [3:0] ST_THR2  = 4'd10;
	localparam logic [3:0] ST_FIN   = 4'd11;

	logic [3:0]       state_q;
	logic [3:0]       ret_q;
	med_src_t         sel_q;
	logic             rr_pend_q;
	logic [IDX_W-1:0] idx_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.med_sel = sel_q;
		cmd.med_idx = idx_q;
		case (state_q)
			ST_IDLE:  cmd.accept    = in_valid;
			ST_CLEAR: cmd.clear     = 1'b1;
			ST_PEAK:  cmd.peak      = 1'b1;
			ST_LEARN: cmd.learn     = 1'b1;
			ST_DET:   cmd.detect    = 1'b1;
			ST_SB:    cmd.sb        = 1'b1;
			ST_REL:   cmd.relearn   = 1'b1;
			ST_MED:   cmd.med_step  = 1'b1;
			ST_MAPP:  cmd.med_apply = 1'b1;
			ST_THR1:  cmd.thr_mul   = 1'b1;
			ST_THR2:  cmd.thr_add   = 1'b1;
			ST_FIN:   cmd.out_load  = !st.out_busy;
			default:  cmd.accept    = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ret_q     <= ST_IDLE;
			sel_q     <= SRC_QRS;
			rr_pend_q <= 1'b0;
			idx_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CLEAR;
				end
				ST_CLEAR: state_q <= ST_PEAK;
				ST_PEAK:  state_q <= st.learning ? ST_LEARN : ST_DET;
				ST_LEARN: begin
					if (st.learn_done) begin
						sel_q     <= SRC_QRS;
						rr_pend_q <= 1'b0;
						ret_q     <= ST_REL;
						idx_q     <= '0;
						state_q   <= ST_MED;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_DET: begin
					idx_q <= '0;
					ret_q <= ST_SB;
					if (st.det_qrs) begin
						sel_q     <= SRC_QRS;
						rr_pend_q <= 1'b1;
						state_q   <= ST_MED;
					end else if (st.det_noise) begin
						sel_q     <= SRC_NOISE;
						rr_pend_q <= 1'b0;
						state_q   <= ST_MED;
					end else begin
						state_q <= ST_SB;
					end
				end
				ST_SB: begin
					idx_q <= '0;
					ret_q <= ST_REL;
					if (st.sb_hit) begin
						sel_q     <= SRC_QRS;
						rr_pend_q <= 1'b1;
						state_q   <= ST_MED;
					end else begin
						state_q <= ST_REL;
					end
				end
				ST_REL: begin
					idx_q <= '0;
					ret_q <= ST_FIN;
					if (st.rel_done) begin
						sel_q     <= SRC_QRS;
						rr_pend_q <= 1'b0;
						state_q   <= ST_MED;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_MED: begin
					if (idx_q == IDX_W'(BUF_DEPTH - 1)) state_q <= ST_MAPP;
					else idx_q <= idx_q + 1'b1;
				end
				ST_MAPP: state_q <= (sel_q == SRC_RR) ? ret_q : ST_THR1;
				ST_THR1: state_q <= ST_THR2;
				ST_THR2: begin
					// A beat also refreshes the RR median before returning.
					if (rr_pend_q) begin
						rr_pend_q <= 1'b0;
						sel_q     <= SRC_RR;
						idx_q     <= '0;
						state_q   <= ST_MED;
					end else begin
						state_q <= ret_q;
					end
				end
				ST_FIN: begin
					if (!st.out_busy) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> src/aqpd_dp.sv
// Datapath of the QRS detector: registers, peak finder, buffers, median counter,
// threshold multiplier and result register. Depends on aqpd_pkg.
`default_nettype none
module aqpd_dp import aqpd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  aqpd_cmd_t             cmd,
	output aqpd_stat_t            st,
	input  logic [SAMPLE_W-1:0]   in_sample,
	input  logic                  in_restart,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DELAY_W-1:0]    out_delay
);

	// Registers written over the configuration channel.
	logic [GAIN_W-1:0] gain_q;
	logic [BYTE_W-1:0] hold_q, pto_q, ww_q, fdly_q;
	logic [SEC_W-1:0]  ss_q, sbmin_q;

	logic [SAMPLE_W-1:0] qrs_q   [BUF_DEPTH];
	logic [SAMPLE_W-1:0] noise_q [BUF_DEPTH];
	logic [COUNT_W-1:0]  rr_q    [BUF_DEPTH];
	logic [SAMPLE_W-1:0] rl_q    [BUF_DEPTH];

	logic [CNT_W-1:0]    lc_q, rc_q;
	logic [SAMPLE_W-1:0] qm_q, nm_q;
	logic [THR_W-1:0]    thr_q;
	logic [COUNT_W-1:0]  sb_q, sbl_q, sbpos_q;
	logic [SAMPLE_W-1:0] sbpk_q, imax_q, hp_q, rm_q, prev_q, x_q, np_q;
	logic [SEC_W-1:0]    timer_q;
	logic [BYTE_W-1:0]   hl_q, sm_q;
	logic                rs_q;
	logic [DELAY_W-1:0]  delay_q;
	logic [MED_W-1:0]    med_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                oval_q;
	logic [DELAY_W-1:0]  odata_q;

	function automatic logic [DELAY_W-1:0] sat_delay(input logic [COUNT_W:0] v);
		logic [DELAY_W-1:0] r;
		r = (v > (COUNT_W+1)'({DELAY_W{1'b1}})) ? {DELAY_W{1'b1}} : v[DELAY_W-1:0];
		return r;
	endfunction

	// Peak finder and hold window.
	logic [BYTE_W-1:0]   sm_inc, sm_n, hl_n;
	logic [SAMPLE_W-1:0] pk, rm_n, hp_n, np_n;

	always_comb begin
		sm_inc = (sm_q != '0 && sm_q != {BYTE_W{1'b1}}) ? sm_q + 1'b1 : sm_q;
		pk     = '0;
		rm_n   = rm_q;
		sm_n   = sm_inc;
		if (x_q > prev_q && x_q > rm_q) begin
			rm_n = x_q;
			if (x_q > SAMPLE_W'(2)) sm_n = BYTE_W'(1);
		end else if ({x_q, 1'b0} < {1'b0, rm_q}) begin
			pk   = rm_q;
			rm_n = '0;
			sm_n = '0;
		end else if (sm_inc > pto_q) begin
			pk   = rm_q;
			rm_n = '0;
			sm_n = '0;
		end
		hp_n = hp_q;
		hl_n = hl_q;
		np_n = '0;
		if (pk != '0 && hl_q == '0) begin
			hp_n = pk;
			hl_n = hold_q;
		end else if (hl_q != '0 && (pk == '0 || pk <= hp_q)) begin
			hl_n = hl_q - 1'b1;
			if (hl_q == BYTE_W'(1)) np_n = hp_q;
		end else if (pk != '0) begin
			hp_n = pk;
			hl_n = hold_q;
		end
	end

	// Shared counters and intervals.
	logic [COUNT_W-1:0] sb_inc, ww_c, gap, back;
	logic [SEC_W-1:0]   timer_nx;
	logic               timer_hit;
	logic [SEC_W+1:0]   ss3;
	logic [SAMPLE_W-1:0] imax_nx;

	always_comb begin
		sb_inc    = (sb_q == {COUNT_W{1'b1}}) ? sb_q : sb_q + 1'b1;
		ww_c      = COUNT_W'(ww_q);
		gap       = (sb_inc >= ww_c) ? sb_inc - ww_c : '0;
		back      = (sb_q >= sbpos_q) ? sb_q - sbpos_q : '0;
		timer_nx  = timer_q + 1'b1;
		timer_hit = (timer_nx == ss_q);
		ss3       = {2'b00, ss_q} + {1'b0, ss_q, 1'b0};
		imax_nx   = (np_q > imax_q) ? np_q : imax_q;
	end

	// Median: one candidate per cycle, ranked against all entries at once.
	logic [MED_W-1:0] src [BUF_DEPTH];
	logic [MED_W-1:0] cand;
	logic [CNT_W-1:0] lt_cnt, le_cnt;
	logic             med_hit;

	always_comb begin
		for (int i = 0; i < BUF_DEPTH; i++) begin
			case (cmd.med_sel)
				SRC_QRS:   src[i] = MED_W'(qrs_q[i]);
				SRC_NOISE: src[i] = MED_W'(noise_q[i]);
				SRC_RR:    src[i] = MED_W'(rr_q[i]);
				default:   src[i] = MED_W'(qrs_q[i]);
			endcase
		end
		cand   = src[cmd.med_idx];
		lt_cnt = '0;
		le_cnt = '0;
		for (int j = 0; j < BUF_DEPTH; j++) begin
			lt_cnt = lt_cnt + CNT_W'(src[j] < cand);
			le_cnt = le_cnt + CNT_W'(src[j] <= cand);
		end
		med_hit = (lt_cnt <= CNT_W'(MED_RANK)) && (le_cnt > CNT_W'(MED_RANK));
	end

	logic [MED_W+1:0] lim_sum;
	logic [COUNT_W-1:0] lim;
	logic signed [SAMPLE_W:0]   diff;
	logic signed [PROD_W-1:0]   off;
	logic [THR_W:0]             thr_sum;

	always_comb begin
		lim_sum = {2'b00, med_q} + {3'b000, med_q[MED_W-1:1]} + (MED_W+2)'(ww_q);
		lim     = (lim_sum > (MED_W+2)'({COUNT_W{1'b1}})) ? {COUNT_W{1'b1}}
			: lim_sum[COUNT_W-1:0];
		diff    = $signed({1'b0, qm_q}) - $signed({1'b0, nm_q});
		off     = prod_q >>> GAIN_FRAC;
		thr_sum = {2'b00, nm_q} + off[THR_W:0];
	end

	always_comb begin
		st.learning   = (lc_q < CNT_W'(BUF_DEPTH));
		st.learn_done = timer_hit && (lc_q == CNT_W'(BUF_DEPTH - 1));
		st.det_qrs    = (np_q != '0) && ({1'b0, np_q} > thr_q);
		st.det_noise  = (np_q != '0) && !({1'b0, np_q} > thr_q);
		st.sb_hit     = (sb_q > sbl_q) && ({sbpk_q, 1'b0} > thr_q);
		st.rel_done   = timer_hit && (rc_q == CNT_W'(BUF_DEPTH - 1));
		st.out_busy   = oval_q && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RST;
			hold_q  <= HOLD_RST;
			ss_q    <= SEC_RST;
			pto_q   <= PTO_RST;
			ww_q    <= WIN_RST;
			fdly_q  <= FDLY_RST;
			sbmin_q <= SBMIN_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_GAIN:  gain_q  <= cfg_data[GAIN_W-1:0];
				CFG_HOLD:  hold_q  <= cfg_data[BYTE_W-1:0];
				CFG_SEC:   ss_q    <= cfg_data[SEC_W-1:0];
				CFG_PTO:   pto_q   <= cfg_data[BYTE_W-1:0];
				CFG_WIN:   ww_q    <= cfg_data[BYTE_W-1:0];
				CFG_FDLY:  fdly_q  <= cfg_data[BYTE_W-1:0];
				CFG_SBMIN: sbmin_q <= cfg_data[SEC_W-1:0];
				default:   gain_q  <= gain_q;
			endcase
		end
	end

	// The re-learn buffer is always written before it is read.
	always_ff @(posedge clk) begin
		if (cmd.relearn && timer_hit) rl_q[rc_q[IDX_W-1:0]] <= imax_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) x_q <= in_sample;
		if (cmd.med_step && med_hit) med_q <= cand;
		if (cmd.thr_mul) prod_q <= diff * $signed({1'b0, gain_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUF_DEPTH; i++) begin
				qrs_q[i]   <= '0;
				noise_q[i] <= '0;
				rr_q[i]    <= COUNT_W'(SEC_RST);
			end
			lc_q    <= '0;
			rc_q    <= '0;
			qm_q    <= '0;
			nm_q    <= '0;
			thr_q   <= '0;
			sb_q    <= '0;
			sbl_q   <= COUNT_W'((int'(SEC_RST) * 3) / 2);
			sbpk_q  <= '0;
			sbpos_q <= '0;
			timer_q <= '0;
			imax_q  <= '0;
			hp_q    <= '0;
			hl_q    <= '0;
			rm_q    <= '0;
			sm_q    <= '0;
			prev_q  <= '0;
			np_q    <= '0;
			rs_q    <= 1'b0;
			delay_q <= '0;
			oval_q  <= 1'b0;
			odata_q <= '0;
		end else begin
			if (cmd.accept) begin
				rs_q    <= in_restart;
				delay_q <= '0;
			end
			if (cmd.clear && rs_q) begin
				for (int i = 0; i < BUF_DEPTH; i++) begin
					qrs_q[i]   <= '0;
					noise_q[i] <= '0;
					rr_q[i]    <= COUNT_W'(ss_q);
				end
				lc_q    <= '0;
				rc_q    <= '0;
				qm_q    <= '0;
				nm_q    <= '0;
				thr_q   <= '0;
				sb_q    <= '0;
				sbl_q   <= COUNT_W'(ss3 >> 1);
				sbpk_q  <= '0;
				sbpos_q <= '0;
				timer_q <= '0;
				imax_q  <= '0;
				hp_q    <= '0;
				hl_q    <= '0;
				rm_q    <= '0;
				sm_q    <= '0;
				prev_q  <= '0;
			end
			if (cmd.peak) begin
				rm_q   <= rm_n;
				sm_q   <= sm_n;
				prev_q <= x_q;
				hp_q   <= hp_n;
				hl_q   <= hl_n;
				np_q   <= np_n;
			end
			if (cmd.learn) begin
				sb_q <= (np_q != '0) ? ww_c : sb_inc;
				if (timer_hit) begin
					timer_q                  <= '0;
					qrs_q[lc_q[IDX_W-1:0]]   <= imax_q;
					lc_q                     <= lc_q + 1'b1;
					imax_q                   <= np_q;
					if (lc_q == CNT_W'(BUF_DEPTH - 1)) begin
						nm_q  <= '0;
						sbl_q <= COUNT_W'(ss3);
					end
				end else begin
					timer_q <= timer_nx;
					imax_q  <= imax_nx;
				end
			end
			if (cmd.detect) begin
				if (st.det_qrs) begin
					for (int i = BUF_DEPTH - 1; i > 0; i--) begin
						qrs_q[i] <= qrs_q[i-1];
						rr_q[i]  <= rr_q[i-1];
					end
					qrs_q[0] <= np_q;
					rr_q[0]  <= gap;
					sb_q     <= ww_c;
					sbpk_q   <= '0;
					imax_q   <= '0;
					delay_q  <= sat_delay((COUNT_W+1)'(ww_q) + (COUNT_W+1)'(fdly_q));
					timer_q  <= '0;
					rc_q     <= '0;
				end else begin
					sb_q <= sb_inc;
					if (st.det_noise) begin
						for (int i = BUF_DEPTH - 1; i > 0; i--) noise_q[i] <= noise_q[i-1];
						noise_q[0] <= np_q;
						if (np_q > sbpk_q && gap >= COUNT_W'(sbmin_q)) begin
							sbpk_q  <= np_q;
							sbpos_q <= gap;
						end
					end
				end
			end
			if (cmd.sb && st.sb_hit) begin
				// Search-back: the best candidate since the last beat counts as a beat.
				for (int i = BUF_DEPTH - 1; i > 0; i--) begin
					qrs_q[i] <= qrs_q[i-1];
					rr_q[i]  <= rr_q[i-1];
				end
				qrs_q[0] <= sbpk_q;
				rr_q[0]  <= sbpos_q;
				sb_q     <= back;
				delay_q  <= sat_delay({1'b0, back} + (COUNT_W+1)'(fdly_q));
				sbpk_q   <= '0;
				timer_q  <= '0;
				imax_q   <= '0;
				rc_q     <= '0;
			end
			if (cmd.relearn) begin
				if (timer_hit) begin
					timer_q <= '0;
					imax_q  <= np_q;
					if (rc_q == CNT_W'(BUF_DEPTH - 1)) begin
						for (int i = 0; i < BUF_DEPTH; i++) begin
							qrs_q[i]   <= (IDX_W'(i) == rc_q[IDX_W-1:0]) ? imax_q : rl_q[i];
							noise_q[i] <= '0;
						end
						nm_q   <= '0;
						sbl_q  <= COUNT_W'(ss3);
						rc_q   <= '0;
						sbpk_q <= '0;
					end else begin
						rc_q <= rc_q + 1'b1;
					end
				end else begin
					timer_q <= timer_nx;
					imax_q  <= imax_nx;
				end
			end
			if (cmd.med_apply) begin
				case (cmd.med_sel)
					SRC_QRS:   qm_q  <= med_q[SAMPLE_W-1:0];
					SRC_NOISE: nm_q  <= med_q[SAMPLE_W-1:0];
					SRC_RR:    sbl_q <= lim;
					default:   qm_q  <= qm_q;
				endcase
			end
			if (cmd.thr_add) thr_q <= thr_sum[THR_W-1:0];
			if (cmd.out_load) begin
				oval_q  <= 1'b1;
				odata_q <= delay_q;
			end else if (out_ready) begin
				oval_q <= 1'b0;
			end
		end
	end

	assign out_valid = oval_q;
	assign out_delay = odata_q;

endmodule
`default_nettype wire

>>> test/tb_adaptive_qrs_peak_detector.sv
// Self-checking testbench of the adaptive QRS peak detector: synthetic ECG beats and noise,
// checked per beat against a cycle-free predictor. Depends on aqpd_pkg, aqpd_if and the RTL.
`default_nettype none
module tb_adaptive_qrs_peak_detector;
	import aqpd_pkg::*;

	localparam int QUIET_LIMIT = 6000;
	localparam int DRAIN_CYCLES = 60;

	typedef logic [31:0] word_buf_t [BUF_DEPTH];
	typedef struct {
		logic [SAMPLE_W-1:0] smp;
		logic                rst;
	} ecg_item_t;
	typedef struct {
		int gain, hold, sec, pto, win, fdly, sbmin, items;
	} setup_t;

	logic clk;
	logic arst_n;

	aqpd_sample_if sample_ch();
	aqpd_result_if result_ch();
	aqpd_cfg_if    cfg();

	adaptive_qrs_peak_detector u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample_ch(sample_ch),
		.result_ch(result_ch),
		.cfg      (cfg)
	);

	ecg_item_t          pend_samples[$];
	logic [DELAY_W-1:0] delay_exp[$];
	int send_idle, recv_idle;
	int mismatches;
	int quiet_cycles;
	int stall_req, stall_seen, stall_left;

	// Register copies kept by the predictor.
	logic [31:0] r_gain, r_hold, r_sec, r_pto, r_win, r_fdly, r_sbmin;
	// Detector state.
	word_buf_t   qrs_buf, noise_buf, rr_buf, relearn_buf;
	logic [31:0] learned_cnt, relearn_cnt, qrs_med, noise_med, thresh;
	logic [31:0] since_beat, sb_limit, sb_peak, sb_pos, sec_timer, intv_max;
	logic [31:0] held_pk, hold_left, run_max, since_max, prev_smp;

	function automatic logic [31:0] lower_median8(input word_buf_t a);
		word_buf_t s;
		logic [31:0] v;
		int i, j;
		s = a;
		for (i = 1; i < BUF_DEPTH; i++) begin
			v = s[i];
			j = i;
			while (j > 0 && s[j-1] > v) begin
				s[j] = s[j-1];
				j--;
			end
			s[j] = v;
		end
		return s[MED_RANK];
	endfunction

	function automatic void shift_in(ref word_buf_t a, input logic [31:0] v);
		int i;
		for (i = BUF_DEPTH - 1; i > 0; i--) a[i] = a[i-1];
		a[0] = v;
	endfunction

	function automatic logic [31:0] sat16(input longint v);
		return (v > 65535) ? 32'd65535 : 32'(v);
	endfunction

	function automatic void recompute_thresh();
		longint d, p, off;
		d = longint'(qrs_med) - longint'(noise_med);
		p = d * longint'(r_gain);
		off = (p >= 0) ? (p / 32768) : -((-p + 32767) / 32768);
		thresh = 32'(longint'(noise_med) + off) & 32'h1FFFF;
	endfunction

	function automatic void limit_from_rr();
		logic [31:0] rr;
		rr = lower_median8(rr_buf);
		sb_limit = sat16(longint'(rr) + longint'(rr / 2) + longint'(r_win));
	endfunction

	function automatic void clear_detector();
		int i;
		for (i = 0; i < BUF_DEPTH; i++) begin
			qrs_buf[i] = 0;
			noise_buf[i] = 0;
			rr_buf[i] = r_sec;
			relearn_buf[i] = 0;
		end
		learned_cnt = 0; relearn_cnt = 0; qrs_med = 0; noise_med = 0; thresh = 0;
		since_beat = 0;
		sb_limit = (r_sec * 3) / 2;
		sb_peak = 0; sb_pos = 0; sec_timer = 0; intv_max = 0;
		held_pk = 0; hold_left = 0; run_max = 0; since_max = 0; prev_smp = 0;
	endfunction

	function automatic logic [31:0] next_peak(input logic [31:0] x);
		logic [31:0] pk;
		pk = 0;
		if (since_max > 0 && since_max < 255) since_max++;
		if (x > prev_smp && x > run_max) begin
			run_max = x;
			if (run_max > 2) since_max = 1;
		end else if (x * 2 < run_max || since_max > r_pto) begin
			pk = run_max;
			run_max = 0;
			since_max = 0;
		end
		prev_smp = x;
		return pk;
	endfunction

	function automatic logic [DELAY_W-1:0] detect_beat(input logic [15:0] smp, input logic rst);
		logic [31:0] x, a, np, dly, gap, back;
		int i;
		x = smp; np = 0; dly = 0;
		if (rst) clear_detector();
		a = next_peak(x);
		if (a != 0 && hold_left == 0) begin
			held_pk = a;
			hold_left = r_hold;
		end else if (a == 0 && hold_left != 0) begin
			hold_left--;
			if (hold_left == 0) np = held_pk;
		end else if (a != 0) begin
			if (a > held_pk) begin
				held_pk = a;
				hold_left = r_hold;
			end else begin
				hold_left--;
				if (hold_left == 0) np = held_pk;
			end
		end

		since_beat = sat16(longint'(since_beat) + 1);
		if (learned_cnt < BUF_DEPTH) begin
			if (np != 0) since_beat = r_win;
			sec_timer = (sec_timer + 1) & 32'h3FF;
			if (sec_timer == r_sec) begin
				sec_timer = 0;
				qrs_buf[learned_cnt] = intv_max;
				intv_max = 0;
				learned_cnt++;
				if (learned_cnt == BUF_DEPTH) begin
					qrs_med = lower_median8(qrs_buf);
					noise_med = 0;
					sb_limit = r_sec * 3;
					recompute_thresh();
				end
			end
			if (np > intv_max) intv_max = np;
		end else begin
			if (np != 0) begin
				gap = (since_beat >= r_win) ? since_beat - r_win : 0;
				if (np > thresh) begin
					shift_in(qrs_buf, np);
					qrs_med = lower_median8(qrs_buf);
					recompute_thresh();
					shift_in(rr_buf, gap);
					limit_from_rr();
					since_beat = r_win;
					sb_peak = 0;
					intv_max = 0;
					dly = r_win + r_fdly;
					sec_timer = 0;
					relearn_cnt = 0;
				end else begin
					shift_in(noise_buf, np);
					noise_med = lower_median8(noise_buf);
					recompute_thresh();
					if (np > sb_peak && gap >= r_sbmin) begin
						sb_peak = np;
						sb_pos = gap;
					end
				end
			end
			// Search-back: take the best earlier candidate as the missed beat.
			if (since_beat > sb_limit && sb_peak * 2 > thresh) begin
				back = (since_beat >= sb_pos) ? since_beat - sb_pos : 0;
				shift_in(qrs_buf, sb_peak);
				qrs_med = lower_median8(qrs_buf);
				recompute_thresh();
				shift_in(rr_buf, sb_pos);
				limit_from_rr();
				since_beat = back;
				dly = back + r_fdly;
				sb_peak = 0; sec_timer = 0; intv_max = 0; relearn_cnt = 0;
			end
		end

		if (learned_cnt == BUF_DEPTH) begin
			sec_timer = (sec_timer + 1) & 32'h3FF;
			if (sec_timer == r_sec) begin
				sec_timer = 0;
				relearn_buf[relearn_cnt % BUF_DEPTH] = intv_max;
				intv_max = 0;
				relearn_cnt++;
				if (relearn_cnt >= BUF_DEPTH) begin
					for (i = 0; i < BUF_DEPTH; i++) begin
						qrs_buf[i] = relearn_buf[i];
						noise_buf[i] = 0;
					end
					qrs_med = lower_median8(relearn_buf);
					noise_med = 0;
					sb_limit = r_sec * 3;
					recompute_thresh();
					sec_timer = 0; intv_max = 0; relearn_cnt = 0; sb_peak = 0;
				end
			end
			if (np > intv_max) intv_max = np;
		end
		return (dly > 4095) ? 12'd4095 : dly[DELAY_W-1:0];
	endfunction

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.filtered_sample = '0;
		sample_ch.restart = 1'b0;
		result_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		forever #1 clk = ~clk;
	end

	// Sample driver: the predictor runs on every accepted beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.filtered_sample <= '0;
			sample_ch.restart <= 1'b0;
		end else begin
			if (sample_ch.valid && sample_ch.ready)
				delay_exp.push_back(detect_beat(sample_ch.filtered_sample, sample_ch.restart));
			if (!sample_ch.valid || sample_ch.ready) begin
				if (pend_samples.size() > 0 && $urandom_range(99) >= send_idle) begin
					sample_ch.valid <= 1'b1;
					sample_ch.filtered_sample <= pend_samples[0].smp;
					sample_ch.restart <= pend_samples[0].rst;
					void'(pend_samples.pop_front());
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random and long back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_seen <= 0;
			stall_left <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (delay_exp.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: qrs_delay=%0d", result_ch.qrs_delay);
				end else begin
					if (result_ch.qrs_delay !== delay_exp[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("qrs_delay mismatch: expected %0d, got %0d",
								delay_exp[0], result_ch.qrs_delay);
					end
					void'(delay_exp.pop_front());
				end
			end
			if (stall_req != stall_seen) begin
				stall_seen <= stall_req;
				stall_left <= 400;
				result_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// Watchdog on cycles with work pending but no beat moving.
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else if (pend_samples.size() > 0 || delay_exp.size() > 0 || sample_ch.valid) begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("** adaptive_qrs_peak_detector: FAILED **");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			CFG_GAIN:  r_gain = val & 32'h7FFF;
			CFG_HOLD:  r_hold = val & 32'hFF;
			CFG_SEC:   r_sec = val & 32'h3FF;
			CFG_PTO:   r_pto = val & 32'hFF;
			CFG_WIN:   r_win = val & 32'hFF;
			CFG_FDLY:  r_fdly = val & 32'hFF;
			CFG_SBMIN: r_sbmin = val & 32'h3FF;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pend_samples.size() > 0 || sample_ch.valid || delay_exp.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_sample(input int v, input bit rst);
		ecg_item_t it;
		it.smp = v[15:0];
		it.rst = rst;
		pend_samples.push_back(it);
	endtask

	// Synthetic ECG: triangular beats on a noisy floor, some beats weak enough
	// to be missed so that search-back has work; a share of raw noise and restarts.
	task automatic add_random(input int n);
		int k, period, amp, nz, ph, v, len;
		k = 0;
		while (k < n) begin
			len = $urandom_range(40, 15);
			if (len > n - k) len = n - k;
			if ($urandom_range(9) < 8) begin
				period = $urandom_range(30, 8);
				amp = $urandom_range(60000, 1000);
				nz = amp / 20 + 1;
				for (int j = 0; j < len; j++) begin
					ph = j % period;
					v = $urandom_range(nz);
					if (ph == 0 && $urandom_range(3) == 0) amp = amp / 3 + 1;
					if (ph < 4) v += amp * (ph + 1) / 4;
					else if (ph < 8) v += amp * (8 - ph) / 4;
					if (v > 65535) v = 65535;
					push_sample(v, $urandom_range(299) == 0);
				end
			end else begin
				for (int j = 0; j < len; j++)
					push_sample($urandom_range(65535), $urandom_range(49) == 0);
			end
			k += len;
		end
	endtask

	setup_t setups[8];
	int ph;

	initial begin
		send_idle = 28; recv_idle = 84;
		mismatches = 0; quiet_cycles = 0; stall_req = 0;
		r_gain = GAIN_RST; r_hold = HOLD_RST; r_sec = SEC_RST; r_pto = PTO_RST;
		r_win = WIN_RST; r_fdly = FDLY_RST; r_sbmin = SBMIN_RST;
		clear_detector();
		setups[0] = '{15565, 3, 10, 6, 4, 57, 5, 130};
		setups[1] = '{0, 1, 1, 1, 1, 0, 0, 110};
		setups[2] = '{32767, 255, 1023, 255, 255, 255, 1023, 90};
		setups[3] = '{20000, 4, 12, 8, 8, 200, 8, 140};
		setups[4] = '{10000, 2, 8, 5, 2, 10, 3, 140};
		setups[5] = '{15565, 0, 0, 19, 16, 57, 72, 40};
		setups[6] = '{15565, 5, 15, 10, 6, 100, 20, 140};
		setups[7] = '{25000, 3, 10, 4, 3, 1, 4, 140};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings first, then a short second so beats come soon.
		push_sample(0, 0); push_sample(65535, 0); push_sample(65535, 0);
		push_sample(0, 0); push_sample(16'h5555, 0); push_sample(16'hAAAA, 0);
		push_sample(65535, 1); push_sample(0, 0);
		drain();
		write_reg(CFG_SEC, 2);
		write_reg(CFG_HOLD, 1);
		write_reg(3'd7, 12345);
		push_sample(0, 1);
		for (int j = 0; j < 16; j++) push_sample((j % 4 == 1) ? 65535 : j * 100, 0);
		drain();

		for (ph = 0; ph < 8; ph++) begin
			case (ph % 3)
				0: begin send_idle = 28; recv_idle = 84; end
				1: begin send_idle = 84; recv_idle = 28; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			write_reg(CFG_GAIN, setups[ph].gain);
			write_reg(CFG_HOLD, setups[ph].hold);
			write_reg(CFG_SEC, setups[ph].sec);
			write_reg(CFG_PTO, setups[ph].pto);
			write_reg(CFG_WIN, setups[ph].win);
			write_reg(CFG_FDLY, setups[ph].fdly);
			write_reg(CFG_SBMIN, setups[ph].sbmin);
			push_sample(0, 1);
			if (ph == 4) begin
				// The sender waits for every outstanding result mid-phase.
				add_random(setups[ph].items / 2);
				while (pend_samples.size() > 0 || sample_ch.valid || delay_exp.size() > 0)
					@(posedge clk);
				add_random(setups[ph].items / 2);
			end else begin
				add_random(setups[ph].items);
			end
			if (ph == 2) stall_req = stall_req + 1;
			drain();
		end

		if (mismatches == 0 && delay_exp.size() == 0)
			$display("** adaptive_qrs_peak_detector: PASSED **");
		else
			$display("** adaptive_qrs_peak_detector: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
src/aqpd_pkg.sv
src/aqpd_if.sv
src/aqpd_ctrl.sv
src/aqpd_dp.sv
src/adaptive_qrs_peak_detector.sv
test/tb_adaptive_qrs_peak_detector.sv
